>>> hdl/mower_mode_supervisor_macros.svh
// Assertion macros used by the mode supervisor RTL.
// Each macro takes a label, a property or expression and a message.
`ifndef MOWER_MODE_SUPERVISOR_MACROS_SVH
`define MOWER_MODE_SUPERVISOR_MACROS_SVH

`ifndef ASSERT_OFF
`define MMS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define MMS_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define MMS_ASSERT(lbl, prop, msg)
`define MMS_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

>>> hdl/mms_pkg.sv
`timescale 1ns / 1ps
package mms_pkg;

	localparam int TIME_W = 32;
	localparam int FLAG_W = 14;
	localparam int ACT_W = 11;
	localparam int TACT_W = 3;
	localparam int CNT_W = 4;
	localparam int STEP_W = 3;
	localparam int REG_IDX_W = 3;

	typedef enum logic [3:0] {
		MODE_IDLE = 4'd0,
		MODE_MOW = 4'd1,
		MODE_DOCK = 4'd2,
		MODE_CHARGE = 4'd3,
		MODE_PAUSE = 4'd4,
		MODE_TEST = 4'd5,
		MODE_SLEEP = 4'd6,
		MODE_MANUAL = 4'd7,
		MODE_ESTOP = 4'd8,
		MODE_MAINT = 4'd9,
		MODE_REMOTE = 4'd10,
		MODE_ERROR = 4'd11,
		MODE_BORDER = 4'd12,
		MODE_LIFTED = 4'd13,
		MODE_RAIN = 4'd14
	} mode_t;

	localparam logic [3:0] MODE_BAD = 4'd15;

	typedef enum logic [2:0] {
		OP_TICK = 3'd0,
		OP_START_MOW = 3'd1,
		OP_DOCK = 3'd2,
		OP_ESTOP = 3'd3,
		OP_MANUAL = 3'd4,
		OP_RESET_ERROR = 3'd5,
		OP_REQUEST = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		NAV_STOPPED = 2'd0,
		NAV_RANDOM = 2'd1,
		NAV_MANUAL = 2'd2
	} nav_t;

	localparam int F_COLLIDE = 0;
	localparam int F_LIFTED = 1;
	localparam int F_CRIT = 2;
	localparam int F_LOW = 3;
	localparam int F_FULL = 4;
	localparam int F_ATDOCK = 5;
	localparam int F_RAIN = 6;
	localparam int F_DOCKFAIL = 7;
	localparam int F_CHGERR = 8;
	localparam int F_BORDER = 9;
	localparam int F_WANTMOW = 10;
	localparam int F_DOCKBORDER = 11;
	localparam int F_DOCKRAIN = 12;
	localparam int F_OBST = 13;

	localparam int A_STOP = 0;
	localparam int A_BLADEOFF = 1;
	localparam int A_STARTMOW = 2;
	localparam int A_STARTDOCK = 3;
	localparam int A_CHGON = 4;
	localparam int A_CHGOFF = 5;
	localparam int A_ESTOP = 6;
	localparam int A_NAV = 7;
	localparam int A_OBST = 8;
	localparam int A_BACKUP = 9;
	localparam int A_BORDER = 10;

	localparam logic [REG_IDX_W-1:0] REG_DOCK_TIMEOUT = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_DOCK_RETRY_WINDOW = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DOCK_MAX_ATTEMPTS = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CHARGE_LIMIT = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MOW_LIMIT = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LIFTED_SETTLE = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_OBSTACLE_PERIOD = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_TEST_INTERVAL = 3'd7;

	// Bit m of row s is set when a change from mode s to mode m is allowed.
	localparam logic [15:0] ALLOW_TAB [0:15] = '{
		16'h0AA6, 16'h0114, 16'h0109, 16'h0103, 16'h0007, 16'h0101, 16'h0009, 16'h0001,
		16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
	};

	typedef struct packed {
		logic [TIME_W-1:0] dock_timeout;
		logic [TIME_W-1:0] dock_retry_window;
		logic [CNT_W-1:0] dock_max_attempts;
		logic [TIME_W-1:0] charge_limit;
		logic [TIME_W-1:0] mow_limit;
		logic [TIME_W-1:0] lifted_settle;
		logic [TIME_W-1:0] obstacle_period;
		logic [TIME_W-1:0] test_interval;
	} cfg_t;

	typedef struct packed {
		mode_t mode;
		mode_t prior;
		logic [TIME_W-1:0] entry_time;
		nav_t nav;
		logic dock_underway;
		logic [TIME_W-1:0] last_dock_try;
		logic [CNT_W-1:0] dock_try_count;
		logic charging_latched;
		logic [TIME_W-1:0] last_obstacle;
		logic error_noted;
		logic [STEP_W-1:0] test_step;
		logic [TIME_W-1:0] last_test;
	} state_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [TIME_W-1:0] now_ms;
		logic [FLAG_W-1:0] sensor_flags;
		logic [3:0] target_state;
	} item_t;

	typedef struct packed {
		mode_t current_mode;
		mode_t prior_mode;
		nav_t nav;
		logic [ACT_W-1:0] pulses;
		logic [TACT_W-1:0] test_action;
		logic accepted;
	} result_t;

	localparam cfg_t CFG_RESET = '{
		dock_timeout: 32'd120000,
		dock_retry_window: 32'd60000,
		dock_max_attempts: 4'd3,
		charge_limit: 32'd3600000,
		mow_limit: 32'd14400000,
		lifted_settle: 32'd2000,
		obstacle_period: 32'd100,
		test_interval: 32'd2000
	};

	localparam state_t STATE_RESET = '{
		mode: MODE_IDLE,
		prior: MODE_IDLE,
		entry_time: '0,
		nav: NAV_STOPPED,
		dock_underway: 1'b0,
		last_dock_try: '0,
		dock_try_count: '0,
		charging_latched: 1'b0,
		last_obstacle: '0,
		error_noted: 1'b0,
		test_step: '0,
		last_test: '0
	};

endpackage

>>> hdl/mower_mode_supervisor.sv
`timescale 1ns / 1ps
// Mode supervisor for a robot mower.
// Input channel: in_valid/in_stall with opcode, now_ms, sensor_flags and
// target_state. An item is either a tick with sensor flags or a command.
// Output channel: out_valid/out_stall with one result per item: the mode,
// the prior mode, the navigation mode, action pulses, the self-test action
// and whether the requested change was taken.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr; write only
// while no request is in flight.
// Path: a request that is taken is held in the input register, and its
// result is loaded into the output register once that register is empty
// or its result is being taken; the receiver takes the result from there.
// Throughput: one request per cycle while out_stall is low; the whole mode
// update is one pass of the step logic from input to state registers.
// When the receiver stalls, the result stays put, one more request may wait
// in the input register, and then in_stall rises until out_stall drops.
// Reset puts the block in idle with all timers and counters cleared and the
// configuration registers at their default values.
`include "mower_mode_supervisor_macros.svh"
module mower_mode_supervisor (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] opcode,
	input logic [mms_pkg::TIME_W-1:0] now_ms,
	input logic [mms_pkg::FLAG_W-1:0] sensor_flags,
	input logic [3:0] target_state,
	output logic out_valid,
	input logic out_stall,
	output logic [3:0] current_mode,
	output logic [3:0] prior_mode,
	output logic [1:0] nav_mode,
	output logic [mms_pkg::ACT_W-1:0] action_pulses,
	output logic [mms_pkg::TACT_W-1:0] test_action,
	output logic accepted,
	input logic cfg_we,
	input logic [mms_pkg::REG_IDX_W-1:0] cfg_addr,
	input logic [mms_pkg::TIME_W-1:0] cfg_wdata
);

	mms_pkg::cfg_t cfg_q;
	mms_pkg::state_t state_q;
	mms_pkg::state_t step_nxt;
	mms_pkg::result_t step_res;
	mms_pkg::item_t item_s1;
	mms_pkg::result_t result_q;
	logic valid_s1;
	logic out_valid_q;
	logic advance;
	logic in_take;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= mms_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				mms_pkg::REG_DOCK_TIMEOUT: cfg_q.dock_timeout <= cfg_wdata;
				mms_pkg::REG_DOCK_RETRY_WINDOW: cfg_q.dock_retry_window <= cfg_wdata;
				mms_pkg::REG_DOCK_MAX_ATTEMPTS:
					cfg_q.dock_max_attempts <= cfg_wdata[mms_pkg::CNT_W-1:0];
				mms_pkg::REG_CHARGE_LIMIT: cfg_q.charge_limit <= cfg_wdata;
				mms_pkg::REG_MOW_LIMIT: cfg_q.mow_limit <= cfg_wdata;
				mms_pkg::REG_LIFTED_SETTLE: cfg_q.lifted_settle <= cfg_wdata;
				mms_pkg::REG_OBSTACLE_PERIOD: cfg_q.obstacle_period <= cfg_wdata;
				mms_pkg::REG_TEST_INTERVAL: cfg_q.test_interval <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
			state_q <= mms_pkg::STATE_RESET;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				state_q <= step_nxt;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.opcode <= opcode;
			item_s1.now_ms <= now_ms;
			item_s1.sensor_flags <= sensor_flags;
			item_s1.target_state <= target_state;
		end
		if (advance) begin
			result_q <= step_res;
		end
	end

	mms_step u_step (
		.cfg(cfg_q),
		.cur(state_q),
		.item(item_s1),
		.nxt(step_nxt),
		.res(step_res)
	);

	assign out_valid = out_valid_q;
	assign current_mode = result_q.current_mode;
	assign prior_mode = result_q.prior_mode;
	assign nav_mode = result_q.nav;
	assign action_pulses = result_q.pulses;
	assign test_action = result_q.test_action;
	assign accepted = result_q.accepted;

	`MMS_ASSERT(a_adv_gives_result, advance |=> out_valid_q, "Processed request left no result")
	`MMS_ASSERT(a_mode_holds, !advance |=> $stable(state_q.mode), "Mode moved without a request")
	`MMS_ASSERT(a_result_matches, out_valid_q |-> result_q.current_mode == state_q.mode, "Result mode differs from state")
	`MMS_ASSERT(a_change_accepted, (advance && step_nxt.mode != state_q.mode) |-> step_res.accepted, "Mode change not flagged as accepted")

endmodule

>>> hdl/mms_step.sv
`timescale 1ns / 1ps
module mms_step (
	input mms_pkg::cfg_t cfg,
	input mms_pkg::state_t cur,
	input mms_pkg::item_t item,
	output mms_pkg::state_t nxt,
	output mms_pkg::result_t res
);

	logic [mms_pkg::FLAG_W-1:0] f;
	logic [mms_pkg::TIME_W-1:0] now;
	logic [mms_pkg::TIME_W-1:0] held;
	logic [mms_pkg::TIME_W-1:0] obst_gap;
	logic [mms_pkg::TIME_W-1:0] try_gap;
	logic [mms_pkg::TIME_W-1:0] test_gap;
	logic obst_due;
	logic [mms_pkg::CNT_W-1:0] cnt_base;

	logic do_ask;
	logic [3:0] ask_to;
	logic [mms_pkg::ACT_W-1:0] hpulse;
	logic [mms_pkg::TACT_W-1:0] tact;
	mms_pkg::state_t side;

	logic may_go;
	logic ok;
	logic change;
	logic [mms_pkg::ACT_W-1:0] enter_pulse;
	mms_pkg::nav_t nav_d;

	assign f = item.sensor_flags;
	assign now = item.now_ms;
	assign held = now - cur.entry_time;
	assign obst_gap = now - cur.last_obstacle;
	assign try_gap = now - cur.last_dock_try;
	assign test_gap = now - cur.last_test;
	assign obst_due = obst_gap > cfg.obstacle_period;
	assign cnt_base = (try_gap > cfg.dock_retry_window) ? '0 : cur.dock_try_count;

	// Decision: which mode change is asked for and what the handler does itself.
	always_comb begin
		do_ask = 1'b0;
		ask_to = mms_pkg::MODE_IDLE;
		hpulse = '0;
		tact = '0;
		side = cur;
		case (item.opcode)
			mms_pkg::OP_TICK: begin
				if ((f[mms_pkg::F_COLLIDE] || f[mms_pkg::F_LIFTED] || f[mms_pkg::F_CRIT]) &&
						cur.mode != mms_pkg::MODE_ESTOP) begin
					do_ask = 1'b1;
					ask_to = mms_pkg::MODE_ESTOP;
				end else begin
					case (cur.mode)
						mms_pkg::MODE_IDLE: begin
							if (f[mms_pkg::F_WANTMOW]) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_MOW;
							end else if ((f[mms_pkg::F_LOW] && !f[mms_pkg::F_ATDOCK]) ||
									f[mms_pkg::F_RAIN]) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_DOCK;
							end
						end
						mms_pkg::MODE_MOW: begin
							if (f[mms_pkg::F_CRIT] || f[mms_pkg::F_LOW]) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_DOCK;
							end else if (f[mms_pkg::F_RAIN]) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_RAIN;
							end else if (f[mms_pkg::F_LIFTED]) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_LIFTED;
							end else if (f[mms_pkg::F_BORDER]) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_BORDER;
							end else begin
								if (obst_due) begin
									side.last_obstacle = now;
								end
								if (obst_due && f[mms_pkg::F_OBST]) begin
									hpulse[mms_pkg::A_OBST] = 1'b1;
								end else if (held > cfg.mow_limit) begin
									do_ask = 1'b1;
									ask_to = mms_pkg::MODE_DOCK;
								end else begin
									hpulse[mms_pkg::A_NAV] = 1'b1;
								end
							end
						end
						mms_pkg::MODE_DOCK: begin
							if (f[mms_pkg::F_ATDOCK]) begin
								side.dock_underway = 1'b0;
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_CHARGE;
							end else if (!cur.dock_underway) begin
								side.dock_underway = 1'b1;
								side.dock_try_count = '0;
								side.last_dock_try = now;
								hpulse[mms_pkg::A_STARTDOCK] = 1'b1;
							end else if (held > cfg.dock_timeout) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_ERROR;
							end else if (f[mms_pkg::F_DOCKFAIL]) begin
								side.dock_try_count = cnt_base;
								if (cnt_base >= cfg.dock_max_attempts) begin
									do_ask = 1'b1;
									ask_to = mms_pkg::MODE_ERROR;
								end else begin
									side.dock_try_count = mms_pkg::CNT_W'(cnt_base + 4'd1);
									side.last_dock_try = now;
									hpulse[mms_pkg::A_STOP] = 1'b1;
									hpulse[mms_pkg::A_BACKUP] = 1'b1;
									hpulse[mms_pkg::A_STARTDOCK] = 1'b1;
								end
							end
						end
						mms_pkg::MODE_CHARGE: begin
							if (!cur.charging_latched && !f[mms_pkg::F_ATDOCK]) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_DOCK;
							end else begin
								if (!cur.charging_latched) begin
									hpulse[mms_pkg::A_CHGON] = 1'b1;
								end
								side.charging_latched = 1'b1;
								if (f[mms_pkg::F_FULL] || f[mms_pkg::F_CHGERR] ||
										!f[mms_pkg::F_ATDOCK] || held > cfg.charge_limit) begin
									hpulse[mms_pkg::A_CHGOFF] = 1'b1;
									side.charging_latched = 1'b0;
									do_ask = 1'b1;
									if (f[mms_pkg::F_FULL]) begin
										ask_to = mms_pkg::MODE_IDLE;
									end else if (f[mms_pkg::F_CHGERR]) begin
										ask_to = mms_pkg::MODE_ERROR;
									end else if (!f[mms_pkg::F_ATDOCK]) begin
										ask_to = mms_pkg::MODE_DOCK;
									end else begin
										ask_to = mms_pkg::MODE_ERROR;
									end
								end
							end
						end
						mms_pkg::MODE_MANUAL: begin
							if (f[mms_pkg::F_CRIT] || f[mms_pkg::F_LIFTED]) begin
								hpulse[mms_pkg::A_STOP] = 1'b1;
								hpulse[mms_pkg::A_BLADEOFF] = 1'b1;
							end else if (f[mms_pkg::F_LOW]) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_DOCK;
							end else if (f[mms_pkg::F_RAIN]) begin
								do_ask = 1'b1;
								ask_to = mms_pkg::MODE_RAIN;
							end
						end
						mms_pkg::MODE_ERROR: begin
							if (!cur.error_noted) begin
								hpulse[mms_pkg::A_STOP] = 1'b1;
								hpulse[mms_pkg::A_BLADEOFF] = 1'b1;
								side.error_noted = 1'b1;
							end
						end
						mms_pkg::MODE_ESTOP, mms_pkg::MODE_MAINT: begin
							hpulse[mms_pkg::A_STOP] = 1'b1;
						end
						mms_pkg::MODE_BORDER: begin
							hpulse[mms_pkg::A_BORDER] = 1'b1;
							do_ask = 1'b1;
							ask_to = f[mms_pkg::F_DOCKBORDER] ? mms_pkg::MODE_DOCK
								: mms_pkg::MODE_MOW;
						end
						mms_pkg::MODE_LIFTED: begin
							hpulse[mms_pkg::A_STOP] = 1'b1;
							if (!f[mms_pkg::F_LIFTED] && held > cfg.lifted_settle) begin
								do_ask = 1'b1;
								ask_to = cur.prior;
							end
						end
						mms_pkg::MODE_RAIN: begin
							if (!f[mms_pkg::F_RAIN]) begin
								do_ask = 1'b1;
								ask_to = f[mms_pkg::F_DOCKRAIN] ? mms_pkg::MODE_DOCK
									: mms_pkg::MODE_MOW;
							end
						end
						mms_pkg::MODE_TEST: begin
							if (test_gap >= cfg.test_interval) begin
								side.last_test = now;
								if (cur.test_step == 3'd7) begin
									hpulse[mms_pkg::A_STOP] = 1'b1;
									hpulse[mms_pkg::A_BLADEOFF] = 1'b1;
									do_ask = 1'b1;
									ask_to = mms_pkg::MODE_IDLE;
								end else begin
									tact = mms_pkg::TACT_W'(cur.test_step + 3'd1);
									side.test_step = mms_pkg::STEP_W'(cur.test_step + 3'd1);
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			mms_pkg::OP_START_MOW: begin
				if (cur.mode == mms_pkg::MODE_IDLE || cur.mode == mms_pkg::MODE_CHARGE) begin
					do_ask = 1'b1;
					ask_to = mms_pkg::MODE_MOW;
				end
			end
			mms_pkg::OP_DOCK: begin
				if (cur.mode == mms_pkg::MODE_IDLE || cur.mode == mms_pkg::MODE_MOW) begin
					do_ask = 1'b1;
					ask_to = mms_pkg::MODE_DOCK;
				end
			end
			mms_pkg::OP_ESTOP: begin
				do_ask = 1'b1;
				ask_to = mms_pkg::MODE_ESTOP;
			end
			mms_pkg::OP_MANUAL: begin
				if (cur.mode == mms_pkg::MODE_IDLE) begin
					do_ask = 1'b1;
					ask_to = mms_pkg::MODE_MANUAL;
				end
			end
			mms_pkg::OP_RESET_ERROR: begin
				if (cur.mode == mms_pkg::MODE_ERROR || cur.mode == mms_pkg::MODE_ESTOP) begin
					do_ask = 1'b1;
					ask_to = cur.prior;
				end
			end
			mms_pkg::OP_REQUEST: begin
				do_ask = 1'b1;
				ask_to = item.target_state;
			end
			default: begin
			end
		endcase
	end

	// Check the request against the transition table.
	always_comb begin
		may_go = cur.mode == mms_pkg::MODE_ERROR || ask_to == mms_pkg::MODE_ERROR ||
			mms_pkg::ALLOW_TAB[cur.mode][ask_to];
		ok = do_ask && ask_to != mms_pkg::MODE_BAD && (ask_to == cur.mode || may_go);
		change = ok && ask_to != cur.mode;
	end

	// Next state and outputs: pulses raised by leaving and entering a mode.
	always_comb begin
		enter_pulse = '0;
		nav_d = cur.nav;
		if (change) begin
			if (cur.mode == mms_pkg::MODE_CHARGE) begin
				enter_pulse[mms_pkg::A_CHGOFF] = 1'b1;
			end
			case (ask_to)
				mms_pkg::MODE_IDLE, mms_pkg::MODE_PAUSE, mms_pkg::MODE_TEST,
				mms_pkg::MODE_SLEEP, mms_pkg::MODE_MAINT: begin
					enter_pulse[mms_pkg::A_STOP] = 1'b1;
					enter_pulse[mms_pkg::A_BLADEOFF] = 1'b1;
					nav_d = mms_pkg::NAV_STOPPED;
				end
				mms_pkg::MODE_MOW: begin
					enter_pulse[mms_pkg::A_STARTMOW] = 1'b1;
					nav_d = mms_pkg::NAV_RANDOM;
				end
				mms_pkg::MODE_DOCK: begin
					enter_pulse[mms_pkg::A_STARTDOCK] = 1'b1;
					nav_d = mms_pkg::NAV_MANUAL;
				end
				mms_pkg::MODE_CHARGE: begin
					enter_pulse[mms_pkg::A_CHGON] = 1'b1;
					nav_d = mms_pkg::NAV_STOPPED;
				end
				mms_pkg::MODE_MANUAL, mms_pkg::MODE_REMOTE: begin
					enter_pulse[mms_pkg::A_STOP] = 1'b1;
					enter_pulse[mms_pkg::A_BLADEOFF] = 1'b1;
					nav_d = mms_pkg::NAV_MANUAL;
				end
				mms_pkg::MODE_ESTOP: begin
					enter_pulse[mms_pkg::A_ESTOP] = 1'b1;
					nav_d = mms_pkg::NAV_STOPPED;
				end
				default: begin
				end
			endcase
		end
		nxt = side;
		if (change) begin
			nxt.prior = cur.mode;
			nxt.mode = mms_pkg::mode_t'(ask_to);
			nxt.entry_time = now;
		end
		nxt.nav = nav_d;
		res.current_mode = nxt.mode;
		res.prior_mode = nxt.prior;
		res.nav = nav_d;
		res.pulses = hpulse | enter_pulse;
		res.test_action = tact;
		res.accepted = ok;
	end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import mms_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 250;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [13:0] FLAGS_NONE = 14'h0000;
	localparam logic [13:0] FLAGS_ALL = 14'h3FFF;

	// Bit m of row s is set when the supervisor may go from mode s to mode m.
	localparam logic [15:0] MODE_MOVES [0:15] = '{
		16'h0AA6, 16'h0114, 16'h0109, 16'h0103, 16'h0007, 16'h0101, 16'h0009, 16'h0001,
		16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
	};

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] opcode;
	logic [TIME_W-1:0] now_ms;
	logic [FLAG_W-1:0] sensor_flags;
	logic [3:0] target_state;
	logic out_valid;
	logic out_stall;
	logic [3:0] current_mode;
	logic [3:0] prior_mode;
	logic [1:0] nav_mode;
	logic [ACT_W-1:0] action_pulses;
	logic [TACT_W-1:0] test_action;
	logic accepted;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_addr;
	logic [TIME_W-1:0] cfg_wdata;

	mower_mode_supervisor dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.now_ms(now_ms),
		.sensor_flags(sensor_flags),
		.target_state(target_state),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.current_mode(current_mode),
		.prior_mode(prior_mode),
		.nav_mode(nav_mode),
		.action_pulses(action_pulses),
		.test_action(test_action),
		.accepted(accepted),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	cfg_t cfg_shadow = CFG_RESET;
	state_t mode_st = STATE_RESET;
	logic [ACT_W-1:0] pulse_acc;
	logic [TACT_W-1:0] step_out;
	logic [TIME_W-1:0] now_cur;
	bit req_made;
	bit req_taken;

	result_t expected_modes[$];
	logic [TIME_W-1:0] clock_ms = '0;
	int failures = 0;
	int cycle_count = 0;
	bit steady = 1'b0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;

	function automatic bit transition_ok(logic [3:0] src, logic [3:0] dst);
		if (src == MODE_ERROR || dst == MODE_ERROR)
			return 1'b1;
		return MODE_MOVES[src][dst];
	endfunction

	function automatic void apply_entry(logic [3:0] m);
		case (m)
			MODE_IDLE, MODE_PAUSE, MODE_TEST, MODE_SLEEP, MODE_MAINT: begin
				pulse_acc[A_STOP] = 1'b1;
				pulse_acc[A_BLADEOFF] = 1'b1;
				mode_st.nav = NAV_STOPPED;
			end
			MODE_MOW: begin
				pulse_acc[A_STARTMOW] = 1'b1;
				mode_st.nav = NAV_RANDOM;
			end
			MODE_DOCK: begin
				pulse_acc[A_STARTDOCK] = 1'b1;
				mode_st.nav = NAV_MANUAL;
			end
			MODE_CHARGE: begin
				pulse_acc[A_CHGON] = 1'b1;
				mode_st.nav = NAV_STOPPED;
			end
			MODE_MANUAL, MODE_REMOTE: begin
				pulse_acc[A_STOP] = 1'b1;
				pulse_acc[A_BLADEOFF] = 1'b1;
				mode_st.nav = NAV_MANUAL;
			end
			MODE_ESTOP: begin
				pulse_acc[A_ESTOP] = 1'b1;
				mode_st.nav = NAV_STOPPED;
			end
			default: ;
		endcase
	endfunction

	function automatic void request_mode(logic [3:0] dst);
		req_made = 1'b1;
		if (dst == MODE_BAD) begin
			req_taken = 1'b0;
		end else if (dst == mode_st.mode) begin
			req_taken = 1'b1;
		end else if (!transition_ok(mode_st.mode, dst)) begin
			req_taken = 1'b0;
		end else begin
			if (mode_st.mode == MODE_CHARGE)
				pulse_acc[A_CHGOFF] = 1'b1;
			mode_st.prior = mode_st.mode;
			mode_st.mode = mode_t'(dst);
			mode_st.entry_time = now_cur;
			apply_entry(dst);
			req_taken = 1'b1;
		end
	endfunction

	function automatic void stop_charging();
		pulse_acc[A_CHGOFF] = 1'b1;
		mode_st.charging_latched = 1'b0;
	endfunction

	function automatic void run_tick(logic [FLAG_W-1:0] f);
		logic [TIME_W-1:0] held;
		held = now_cur - mode_st.entry_time;
		if ((f[F_COLLIDE] || f[F_LIFTED] || f[F_CRIT]) && mode_st.mode != MODE_ESTOP) begin
			request_mode(MODE_ESTOP);
			return;
		end
		case (mode_st.mode)
			MODE_IDLE: begin
				if (f[F_WANTMOW])
					request_mode(MODE_MOW);
				else if (f[F_LOW] && !f[F_ATDOCK])
					request_mode(MODE_DOCK);
				else if (f[F_RAIN])
					request_mode(MODE_DOCK);
			end
			MODE_MOW: begin
				if (f[F_CRIT] || f[F_LOW]) begin
					request_mode(MODE_DOCK);
				end else if (f[F_RAIN]) begin
					request_mode(MODE_RAIN);
				end else if (f[F_LIFTED]) begin
					request_mode(MODE_LIFTED);
				end else if (f[F_BORDER]) begin
					request_mode(MODE_BORDER);
				end else begin
					if (now_cur - mode_st.last_obstacle > cfg_shadow.obstacle_period) begin
						mode_st.last_obstacle = now_cur;
						if (f[F_OBST]) begin
							pulse_acc[A_OBST] = 1'b1;
							return;
						end
					end
					if (held > cfg_shadow.mow_limit)
						request_mode(MODE_DOCK);
					else
						pulse_acc[A_NAV] = 1'b1;
				end
			end
			MODE_DOCK: begin
				if (f[F_ATDOCK]) begin
					mode_st.dock_underway = 1'b0;
					request_mode(MODE_CHARGE);
				end else if (!mode_st.dock_underway) begin
					mode_st.dock_underway = 1'b1;
					mode_st.dock_try_count = '0;
					pulse_acc[A_STARTDOCK] = 1'b1;
					mode_st.last_dock_try = now_cur;
				end else if (held > cfg_shadow.dock_timeout) begin
					request_mode(MODE_ERROR);
				end else if (f[F_DOCKFAIL]) begin
					if (now_cur - mode_st.last_dock_try > cfg_shadow.dock_retry_window)
						mode_st.dock_try_count = '0;
					if (mode_st.dock_try_count >= cfg_shadow.dock_max_attempts) begin
						request_mode(MODE_ERROR);
					end else begin
						mode_st.dock_try_count = mode_st.dock_try_count + 1'b1;
						mode_st.last_dock_try = now_cur;
						pulse_acc[A_STOP] = 1'b1;
						pulse_acc[A_BACKUP] = 1'b1;
						pulse_acc[A_STARTDOCK] = 1'b1;
					end
				end
			end
			MODE_CHARGE: begin
				if (!mode_st.charging_latched && !f[F_ATDOCK]) begin
					request_mode(MODE_DOCK);
				end else begin
					if (!mode_st.charging_latched) begin
						pulse_acc[A_CHGON] = 1'b1;
						mode_st.charging_latched = 1'b1;
					end
					if (f[F_FULL]) begin
						stop_charging();
						request_mode(MODE_IDLE);
					end else if (f[F_CHGERR]) begin
						stop_charging();
						request_mode(MODE_ERROR);
					end else if (!f[F_ATDOCK]) begin
						stop_charging();
						request_mode(MODE_DOCK);
					end else if (held > cfg_shadow.charge_limit) begin
						stop_charging();
						request_mode(MODE_ERROR);
					end
				end
			end
			MODE_MANUAL: begin
				if (f[F_CRIT] || f[F_LIFTED]) begin
					pulse_acc[A_STOP] = 1'b1;
					pulse_acc[A_BLADEOFF] = 1'b1;
				end else if (f[F_LOW]) begin
					request_mode(MODE_DOCK);
				end else if (f[F_RAIN]) begin
					request_mode(MODE_RAIN);
				end
			end
			MODE_ERROR: begin
				if (!mode_st.error_noted) begin
					pulse_acc[A_STOP] = 1'b1;
					pulse_acc[A_BLADEOFF] = 1'b1;
					mode_st.error_noted = 1'b1;
				end
			end
			MODE_ESTOP, MODE_MAINT: begin
				pulse_acc[A_STOP] = 1'b1;
			end
			MODE_BORDER: begin
				pulse_acc[A_BORDER] = 1'b1;
				request_mode(f[F_DOCKBORDER] ? MODE_DOCK : MODE_MOW);
			end
			MODE_LIFTED: begin
				pulse_acc[A_STOP] = 1'b1;
				if (!f[F_LIFTED] && held > cfg_shadow.lifted_settle)
					request_mode(mode_st.prior);
			end
			MODE_RAIN: begin
				if (!f[F_RAIN])
					request_mode(f[F_DOCKRAIN] ? MODE_DOCK : MODE_MOW);
			end
			MODE_TEST: begin
				if (now_cur - mode_st.last_test >= cfg_shadow.test_interval) begin
					mode_st.last_test = now_cur;
					if (mode_st.test_step >= 3'd7) begin
						pulse_acc[A_STOP] = 1'b1;
						pulse_acc[A_BLADEOFF] = 1'b1;
						request_mode(MODE_IDLE);
					end else begin
						step_out = mode_st.test_step + 1'b1;
						mode_st.test_step = mode_st.test_step + 1'b1;
					end
				end
			end
			default: ;
		endcase
	endfunction

	function automatic result_t predict_mode_update(logic [2:0] op, logic [TIME_W-1:0] t,
			logic [FLAG_W-1:0] f, logic [3:0] tgt);
		result_t r;
		now_cur = t;
		pulse_acc = '0;
		step_out = '0;
		req_made = 1'b0;
		req_taken = 1'b0;
		case (op)
			OP_TICK: run_tick(f);
			OP_START_MOW: begin
				if (mode_st.mode == MODE_IDLE || mode_st.mode == MODE_CHARGE)
					request_mode(MODE_MOW);
			end
			OP_DOCK: begin
				if (mode_st.mode == MODE_IDLE || mode_st.mode == MODE_MOW)
					request_mode(MODE_DOCK);
			end
			OP_ESTOP: request_mode(MODE_ESTOP);
			OP_MANUAL: begin
				if (mode_st.mode == MODE_IDLE)
					request_mode(MODE_MANUAL);
			end
			OP_RESET_ERROR: begin
				if (mode_st.mode == MODE_ERROR || mode_st.mode == MODE_ESTOP)
					request_mode(mode_st.prior);
			end
			OP_REQUEST: request_mode(tgt);
			default: ;
		endcase
		r.current_mode = mode_st.mode;
		r.prior_mode = mode_st.prior;
		r.nav = mode_st.nav;
		r.pulses = pulse_acc;
		r.test_action = step_out;
		r.accepted = req_made && req_taken;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	function automatic logic [FLAG_W-1:0] flag_mask(int idx);
		logic [FLAG_W-1:0] m;
		m = '0;
		m[idx] = 1'b1;
		return m;
	endfunction

	function automatic logic [TIME_W-1:0] later(logic [TIME_W-1:0] delta);
		clock_ms = clock_ms + delta;
		return clock_ms;
	endfunction

	function automatic logic [TIME_W-1:0] next_time();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return later($urandom_range(0, 3000));
		if (r < 90)
			return later($urandom_range(0, 200000));
		if (r < 97)
			return later($urandom_range(0, 20000000));
		clock_ms = $urandom;
		return clock_ms;
	endfunction

	function automatic logic [FLAG_W-1:0] random_flags();
		logic [FLAG_W-1:0] f;
		f = FLAG_W'($urandom_range(0, 16383));
		f[F_COLLIDE] = ($urandom_range(0, 99) < 4);
		f[F_LIFTED] = ($urandom_range(0, 99) < 4);
		f[F_CRIT] = ($urandom_range(0, 99) < 4);
		return f;
	endfunction

	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen = hold_asks;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (steady) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 10);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_modes.size() == 0) begin
				$error("result with no request pending: current_mode %0d", current_mode);
				failures++;
			end else begin
				want = expected_modes.pop_front();
				check_field("current_mode", want.current_mode, current_mode);
				check_field("prior_mode", want.prior_mode, prior_mode);
				check_field("nav_mode", want.nav, nav_mode);
				check_field("action_pulses", want.pulses, action_pulses);
				check_field("test_action", want.test_action, test_action);
				check_field("accepted", want.accepted, accepted);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_request(logic [2:0] op, logic [TIME_W-1:0] t, logic [FLAG_W-1:0] f,
			logic [3:0] tgt);
		int gap;
		in_valid <= 1'b1;
		opcode <= op;
		now_ms <= t;
		sensor_flags <= f;
		target_state <= tgt;
		do
			@(posedge clk);
		while (in_stall);
		expected_modes.push_back(predict_mode_update(op, t, f, tgt));
		if (!steady && $urandom_range(0, 99) < 10) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_modes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_settings(input logic [31:0] vals [8]);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_addr <= REG_IDX_W'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			case (i)
				REG_DOCK_TIMEOUT: cfg_shadow.dock_timeout = vals[i];
				REG_DOCK_RETRY_WINDOW: cfg_shadow.dock_retry_window = vals[i];
				REG_DOCK_MAX_ATTEMPTS: cfg_shadow.dock_max_attempts = vals[i][CNT_W-1:0];
				REG_CHARGE_LIMIT: cfg_shadow.charge_limit = vals[i];
				REG_MOW_LIMIT: cfg_shadow.mow_limit = vals[i];
				REG_LIFTED_SETTLE: cfg_shadow.lifted_settle = vals[i];
				REG_OBSTACLE_PERIOD: cfg_shadow.obstacle_period = vals[i];
				REG_TEST_INTERVAL: cfg_shadow.test_interval = vals[i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	task automatic test_random_traffic(int count);
		int unsigned pick;
		logic [2:0] op;
		logic [3:0] tgt;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			tgt = 4'($urandom_range(0, 15));
			if (pick < 55) begin
				op = OP_TICK;
			end else if (pick < 73) begin
				op = OP_REQUEST;
				if ($urandom_range(0, 99) < 25)
					tgt = MODE_ERROR;
				else if (tgt == MODE_BAD && $urandom_range(0, 3) != 0)
					tgt = MODE_IDLE;
			end else if (pick < 78) begin
				op = OP_START_MOW;
			end else if (pick < 83) begin
				op = OP_DOCK;
			end else if (pick < 87) begin
				op = OP_ESTOP;
			end else if (pick < 92) begin
				op = OP_MANUAL;
			end else if (pick < 99) begin
				op = OP_RESET_ERROR;
			end else begin
				op = OP_UNUSED;
			end
			send_request(op, next_time(), random_flags(), tgt);
		end
	endtask

	task automatic test_unused_and_bad_codes();
		send_request(OP_UNUSED, 32'hFFFF_FFFF, FLAGS_ALL, MODE_BAD);
		send_request(OP_REQUEST, 32'hFFFF_FFFF, FLAGS_NONE, MODE_BAD);
		send_request(OP_REQUEST, clock_ms, FLAGS_NONE, MODE_IDLE);
	endtask

	task automatic test_manual_and_mow();
		send_request(OP_MANUAL, later(100), FLAGS_NONE, MODE_IDLE);
		send_request(OP_REQUEST, later(100), FLAGS_NONE, MODE_IDLE);
		send_request(OP_START_MOW, later(100), FLAGS_NONE, MODE_IDLE);
		send_request(OP_TICK, later(500), flag_mask(F_OBST), MODE_IDLE);
		send_request(OP_TICK, later(500), FLAGS_NONE, MODE_IDLE);
	endtask

	task automatic test_dock_and_charge();
		send_request(OP_DOCK, later(100), FLAGS_NONE, MODE_IDLE);
		send_request(OP_TICK, later(100), FLAGS_NONE, MODE_IDLE);
		send_request(OP_TICK, later(100), flag_mask(F_DOCKFAIL), MODE_IDLE);
		send_request(OP_TICK, later(100), flag_mask(F_ATDOCK), MODE_IDLE);
		send_request(OP_TICK, later(100), flag_mask(F_ATDOCK), MODE_IDLE);
		send_request(OP_TICK, later(100), flag_mask(F_ATDOCK) | flag_mask(F_FULL), MODE_IDLE);
	endtask

	task automatic test_emergency_and_recovery();
		send_request(OP_TICK, later(100), FLAGS_ALL, MODE_REMOTE);
		send_request(OP_TICK, later(100), FLAGS_NONE, MODE_IDLE);
		send_request(OP_RESET_ERROR, later(100), FLAGS_NONE, MODE_IDLE);
		send_request(OP_ESTOP, later(100), FLAGS_NONE, MODE_IDLE);
	endtask

	task automatic test_error_and_self_test();
		send_request(OP_REQUEST, later(100), FLAGS_NONE, MODE_ERROR);
		send_request(OP_TICK, later(100), FLAGS_NONE, MODE_IDLE);
		send_request(OP_REQUEST, later(100), FLAGS_NONE, MODE_TEST);
		repeat (8)
			send_request(OP_TICK, later(cfg_shadow.test_interval), FLAGS_NONE, MODE_IDLE);
	endtask

	task automatic test_steady_stream();
		steady = 1'b1;
		test_random_traffic(200);
		steady = 1'b0;
	endtask

	task automatic test_register_extremes();
		logic [31:0] vals [8];
		settle();
		vals = '{default: 32'h0000_0000};
		program_settings(vals);
		test_random_traffic(250);
		settle();
		vals = '{default: 32'hFFFF_FFFF};
		program_settings(vals);
		test_random_traffic(250);
	endtask

	task automatic test_backpressure();
		hold_asks++;
		test_random_traffic(100);
	endtask

	task automatic test_random_settings();
		logic [31:0] vals [8];
		repeat (3) begin
			settle();
			for (int i = 0; i < 8; i++)
				vals[i] = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 5000) :
						$urandom_range(0, 300000);
			vals[REG_DOCK_MAX_ATTEMPTS] = $urandom;
			program_settings(vals);
			test_random_traffic(250);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_TICK;
		now_ms <= '0;
		sensor_flags <= '0;
		target_state <= MODE_IDLE;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_DOCK_TIMEOUT;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_unused_and_bad_codes();
		test_manual_and_mow();
		test_dock_and_charge();
		test_emergency_and_recovery();
		test_error_and_self_test();
		test_random_traffic(400);
		test_steady_stream();
		test_register_extremes();
		test_backpressure();
		test_random_settings();

		settle();
		repeat (8) @(posedge clk);
		if (expected_modes.size() != 0) begin
			$error("%0d results never arrived", expected_modes.size());
			failures++;
		end
		if (failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
